>>> rtl/framed_response_receiver_unit_defines.svh
// ----------------------------------------------------------------------------
// framed response receiver assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef FRAMED_RESPONSE_RECEIVER_UNIT_DEFINES_SVH
`define FRAMED_RESPONSE_RECEIVER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define FRR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frr port check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define FRR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frr port check failed");

`endif

>>> rtl/frr_pkg.sv
// ----------------------------------------------------------------------------
// frr_pkg
// types and constants of the framed response receiver
// ----------------------------------------------------------------------------
`default_nettype none

package frr_pkg;

	// operation codes
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// framing characters
	localparam logic [7:0] CODE_SOH = 8'h01;
	localparam logic [7:0] CODE_STX = 8'h02;
	localparam logic [7:0] CODE_ETX = 8'h03;
	localparam logic [7:0] CODE_EOT = 8'h04;

	localparam logic [1:0]  HEADER_BYTES = 2'd3;
	localparam logic [11:0] KEEP_MAX     = 12'd4095;

	// configuration register indexes
	localparam logic [1:0] CFG_OVERALL = 2'd0;
	localparam logic [1:0] CFG_GAP     = 2'd1;
	localparam logic [1:0] CFG_BUFFER  = 2'd2;

	localparam logic [15:0] OVERALL_RESET = 16'd1000;
	localparam logic [9:0]  GAP_RESET     = 10'd200;
	localparam logic [12:0] BUFFER_RESET  = 13'd64;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_HUNT_SOH = 3'd1,
		PH_HEADER   = 3'd2,
		PH_HUNT_STX = 3'd3,
		PH_PAYLOAD  = 3'd4
	} phase_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic        valid;
		logic        kind;
		logic [7:0]  payload_byte;
		logic        status;
		logic [11:0] byte_count;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/frr_in_reg.sv
// ----------------------------------------------------------------------------
// frr_in_reg
// input register stage; holds one request until the core takes it
// ----------------------------------------------------------------------------
`default_nettype none

module frr_in_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire frr_pkg::item_t in_item,
	input  wire logic          advance,
	output logic               valid_s1,
	output frr_pkg::item_t     item_s1
);

	// free slot, or the held request leaves this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

>>> rtl/frr_core.sv
// ----------------------------------------------------------------------------
// frr_core
// frame state machine, timeout counters and configuration registers
// ----------------------------------------------------------------------------
`default_nettype none

module frr_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_write,
	input  wire logic [1:0]     cfg_index,
	input  wire logic [15:0]    cfg_data,
	input  wire logic           go,
	input  wire frr_pkg::item_t item,
	output frr_pkg::result_t    result
);

	logic [15:0] overall_q;
	logic [9:0]  gap_cfg_q;
	logic [12:0] buffer_q;

	frr_pkg::phase_t phase_q, phase_d;
	logic [15:0] elapsed_q, elapsed_d, elapsed_inc;
	logic [9:0]  gap_q, gap_d, gap_inc;
	logic [1:0]  header_q, header_d;
	logic [11:0] kept_q, kept_d;
	logic        room;
	logic        overall_hit;
	logic        gap_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overall_q <= frr_pkg::OVERALL_RESET;
			gap_cfg_q <= frr_pkg::GAP_RESET;
			buffer_q  <= frr_pkg::BUFFER_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				frr_pkg::CFG_OVERALL: begin
					overall_q <= cfg_data;
				end
				frr_pkg::CFG_GAP: begin
					gap_cfg_q <= cfg_data[9:0];
				end
				frr_pkg::CFG_BUFFER: begin
					buffer_q <= cfg_data[12:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= frr_pkg::PH_IDLE;
			elapsed_q <= '0;
			gap_q     <= '0;
			header_q  <= '0;
			kept_q    <= '0;
		end else begin
			phase_q   <= phase_d;
			elapsed_q <= elapsed_d;
			gap_q     <= gap_d;
			header_q  <= header_d;
			kept_q    <= kept_d;
		end
	end

	// saturating counters and limit compares
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 16'd1;
	assign gap_inc     = (gap_q == '1) ? gap_q : gap_q + 10'd1;
	assign overall_hit = (elapsed_inc >= overall_q);
	assign gap_hit     = (gap_inc >= gap_cfg_q);
	assign room        = (({1'b0, kept_q} + 13'd1) < buffer_q) && (kept_q < frr_pkg::KEEP_MAX);

	always_comb begin
		phase_d   = phase_q;
		elapsed_d = elapsed_q;
		gap_d     = gap_q;
		header_d  = header_q;
		kept_d    = kept_q;
		result    = '0;
		if (go) begin
			priority if (item.operation == frr_pkg::OP_START) begin
				phase_d   = frr_pkg::PH_HUNT_SOH;
				elapsed_d = '0;
				gap_d     = '0;
				header_d  = '0;
				kept_d    = '0;
			end else if (phase_q == frr_pkg::PH_IDLE) begin
				phase_d = phase_q;
			end else if (item.operation == frr_pkg::OP_BYTE) begin
				gap_d = '0;
				unique case (phase_q)
					frr_pkg::PH_HUNT_SOH: begin
						if (item.rx_byte == frr_pkg::CODE_SOH) begin
							phase_d  = frr_pkg::PH_HEADER;
							header_d = frr_pkg::HEADER_BYTES;
						end
					end
					frr_pkg::PH_HEADER: begin
						header_d = header_q - 2'd1;
						if (header_q == 2'd1) begin
							phase_d = frr_pkg::PH_HUNT_STX;
						end
					end
					frr_pkg::PH_HUNT_STX: begin
						if (item.rx_byte == frr_pkg::CODE_STX) begin
							phase_d = frr_pkg::PH_PAYLOAD;
						end
					end
					frr_pkg::PH_PAYLOAD: begin
						if (item.rx_byte == frr_pkg::CODE_ETX ||
						    item.rx_byte == frr_pkg::CODE_EOT) begin
							phase_d           = frr_pkg::PH_IDLE;
							result.valid      = 1'b1;
							result.kind       = 1'b1;
							result.byte_count = kept_q;
							result.last       = 1'b1;
						end else if (room) begin
							kept_d              = kept_q + 12'd1;
							result.valid        = 1'b1;
							result.payload_byte = item.rx_byte;
						end
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end else if (item.operation == frr_pkg::OP_TICK) begin
				elapsed_d = elapsed_inc;
				unique case (phase_q)
					frr_pkg::PH_HUNT_SOH, frr_pkg::PH_HUNT_STX: begin
						if (overall_hit) begin
							phase_d       = frr_pkg::PH_IDLE;
							result.valid  = 1'b1;
							result.kind   = 1'b1;
							result.status = 1'b1;
							result.last   = 1'b1;
						end
					end
					frr_pkg::PH_HEADER: begin
						gap_d = gap_inc;
						if (gap_hit) begin
							phase_d       = frr_pkg::PH_IDLE;
							result.valid  = 1'b1;
							result.kind   = 1'b1;
							result.status = 1'b1;
							result.last   = 1'b1;
						end
					end
					frr_pkg::PH_PAYLOAD: begin
						gap_d = gap_inc;
						if (gap_hit || overall_hit) begin
							phase_d           = frr_pkg::PH_IDLE;
							result.valid      = 1'b1;
							result.kind       = 1'b1;
							result.byte_count = kept_q;
							result.last       = 1'b1;
						end
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end else begin
				// unused operation code leaves the state alone
				phase_d = phase_q;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/frr_out_reg.sv
// ----------------------------------------------------------------------------
// frr_out_reg
// result register; holds a result until the sink takes it
// ----------------------------------------------------------------------------
`default_nettype none

module frr_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire frr_pkg::result_t result,
	input  wire logic             out_ready,
	output logic                  can_take,
	output logic                  out_valid,
	output frr_pkg::result_t      result_q
);

	logic valid_q;

	assign can_take  = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_take) begin
			valid_q <= load && result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && load && result.valid) begin
			result_q <= result;
		end
	end

endmodule

`default_nettype wire

>>> rtl/framed_response_receiver_unit.sv
// ----------------------------------------------------------------------------
// framed_response_receiver_unit
// receives one reply frame (SOH, three header bytes, STX, payload, ETX/EOT)
// from a byte stream with millisecond timeouts
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload
//  -------   -------------------   -----------------------------------------
//  input     in_valid / in_ready   operation, rx_byte
//  output    out_valid / out_ready kind, payload_byte, status, byte_count, last
//  config    cfg_write             cfg_index, cfg_data (no handshake back)
//
// one request per cycle sustained while the sink takes results; a request waits in the
// input register, then the frame state machine updates and loads the result register
// reset clears the state machine, counters and valid flags; config registers
// return to 1000 ms overall, 200 ms gap, 64 byte buffer
// a result held by a stalled sink holds the input register, which stops in_ready
// ----------------------------------------------------------------------------
`default_nettype none

module framed_response_receiver_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  rx_byte,
	// result channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             kind,
	output logic [7:0]       payload_byte,
	output logic             status,
	output logic [11:0]      byte_count,
	output logic             last,
	// configuration writes
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	frr_pkg::item_t   in_item;
	frr_pkg::item_t   item_s1;
	frr_pkg::result_t result;
	frr_pkg::result_t result_q;
	logic             valid_s1;
	logic             can_take;
	logic             advance;

	assign in_item.operation = operation;
	assign in_item.rx_byte   = rx_byte;

	// the held request is processed once the result register has room
	assign advance = valid_s1 && can_take;

	frr_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// state machine and timeouts; state moves only on an advancing request
	frr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.go        (advance),
		.item      (item_s1),
		.result    (result)
	);

	// requests that produce no result simply drop out here
	frr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.result    (result),
		.out_ready (out_ready),
		.can_take  (can_take),
		.out_valid (out_valid),
		.result_q  (result_q)
	);

	assign kind         = result_q.kind;
	assign payload_byte = result_q.payload_byte;
	assign status       = result_q.status;
	assign byte_count   = result_q.byte_count;
	assign last         = result_q.last;

endmodule

`default_nettype wire

>>> rtl/frr_checker.sv
// ----------------------------------------------------------------------------
// frr_checker
// port-level checks on the result channel of the receiver
// ----------------------------------------------------------------------------
`default_nettype none

`include "framed_response_receiver_unit_defines.svh"

module frr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        kind,
	input wire logic [7:0]  payload_byte,
	input wire logic        status,
	input wire logic [11:0] byte_count,
	input wire logic        last
);

	logic [22:0] out_fields;

	assign out_fields = {kind, payload_byte, status, byte_count, last};

	// stalled result stays put
	`FRR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_fields))
	// payload results carry nothing else
	`FRR_ASSERT_NOW(a_payload_clean, out_valid && !kind, !last && !status && byte_count == 12'd0)
	// a finish closes the reception and has no payload byte
	`FRR_ASSERT_NOW(a_finish_last, out_valid && kind, last && payload_byte == 8'd0)
	// a failure reports no count
	`FRR_ASSERT_NOW(a_fail_count, out_valid && status, kind && byte_count == 12'd0)

endmodule

bind framed_response_receiver_unit frr_checker u_frr_checker (.*);

`default_nettype wire
